// ===== hdl/tmq_pkg.sv =====
// Package for the text marquee scroller: sizes, codes and shared types.
// No dependencies; tmq_window and the top level import it.

package tmq_pkg;

    localparam int MSG_DEPTH = 64;
    localparam int WIN_DEPTH = 64;

    localparam int MSG_IDX_W = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

    // Field widths fixed by the interface
    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 6;
    localparam int POS_W     = 6;
    localparam int DIV_W     = 8;
    localparam int LEN_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DIV  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    // Control bundle from the sequencer to the window shift line
    typedef struct packed {
        logic              clear;
        logic              advance;
        logic              rotate;
        logic              dir;
        logic [CHAR_W-1:0] feed_char;
    } win_ctrl_t;

endpackage

// ===== hdl/tmq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module tmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/tmq_window.sv =====
// Window shift line: clear, advance with a new character, or rotate for readout.
// Depends on tmq_pkg.

module tmq_window
    import tmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  win_ctrl_t            ctrl,
    input  logic [WIN_IDX_W-1:0] last_idx,
    output logic [CHAR_W-1:0]    head
);

    logic [CHAR_W-1:0] cell_reg  [WIN_DEPTH];
    logic [CHAR_W-1:0] cell_next [WIN_DEPTH];

    genvar g;
    generate
        for (g = 0; g < WIN_DEPTH; g++)
        begin : g_cell
            localparam int NXT = (g + 1) % WIN_DEPTH;
            localparam int PRV = (g + WIN_DEPTH - 1) % WIN_DEPTH;
            localparam logic [WIN_IDX_W-1:0] IDX = WIN_IDX_W'(g);

            always_comb
            begin
                cell_next[g] = cell_reg[g];
                if (ctrl.clear)
                begin
                    cell_next[g] = SPACE_CODE;
                end
                else if (ctrl.advance && ctrl.dir)
                begin
                    if (IDX == '0)
                    begin
                        cell_next[g] = ctrl.feed_char;
                    end
                    else if (IDX <= last_idx)
                    begin
                        cell_next[g] = cell_reg[PRV];
                    end
                end
                else if (ctrl.advance || ctrl.rotate)
                begin
                    if (IDX < last_idx)
                    begin
                        cell_next[g] = cell_reg[NXT];
                    end
                    else if (IDX == last_idx)
                    begin
                        cell_next[g] = ctrl.rotate ? cell_reg[0] : ctrl.feed_char;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cell_reg[g] <= SPACE_CODE;
                end
                else
                begin
                    cell_reg[g] <= cell_next[g];
                end
            end
        end
    endgenerate

    assign head = cell_reg[0];

endmodule

// ===== hdl/text_marquee_scroller_top.sv =====
// Top level of the text marquee scroller: sequencer, counters and config.
// Depends on tmq_pkg, tmq_ram and tmq_window.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  item     | item_valid/item_ready, command,           | in
//           | char_index, char_value                    |
//  result   | result_valid/result_ready, position,      | out
//           | glyph, last                               |
//  config   | cfg_write, cfg_index, cfg_data            | in
//
// A write, restart, skipped tick or unused command is handled in ST_IDLE.
// An advancing tick reads the message RAM, shifts the window in ST_SHIFT,
// then in ST_EMIT gives one result beat per window position, paced by
// the single head tap of the rotating window line.
// Reset fills the window with spaces and clears every counter at once.
// A stalled result beat holds the window; no new item is taken until the
// last beat of the run has gone.

module text_marquee_scroller_top
    import tmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [CMD_W-1:0]     command,
    input  logic [IDX_W-1:0]     char_index,
    input  logic [CHAR_W-1:0]    char_value,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [POS_W-1:0]     position,
    output logic [CHAR_W-1:0]    glyph,
    output logic                 last,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam logic [LEN_W-1:0] MSG_DEPTH_L = LEN_W'(MSG_DEPTH);
    localparam logic [LEN_W-1:0] WIN_DEPTH_L = LEN_W'(WIN_DEPTH);

    state_t state_reg, state_next;

    logic             direction_reg;
    logic [DIV_W-1:0] step_div_reg;
    logic [LEN_W-1:0] msg_len_reg;
    logic [LEN_W-1:0] win_width_reg;

    logic [LEN_W-1:0]     msg_ptr_reg, msg_ptr_next;
    logic [LEN_W-1:0]     gap_cnt_reg, gap_cnt_next;
    logic [DIV_W-1:0]     tick_cnt_reg, tick_cnt_next;
    logic [WIN_IDX_W-1:0] pos_reg, pos_next;
    logic                 feed_space_reg, feed_space_next;

    logic [LEN_W-1:0]     len_eff;
    logic [LEN_W-1:0]     width_eff;
    logic [WIN_IDX_W-1:0] last_idx;
    logic [LEN_W-1:0]     fetch_k;
    logic [LEN_W-1:0]     fetch_idx;

    logic                 item_beat;
    logic                 ram_we;
    logic [CHAR_W-1:0]    ram_rdata;
    win_ctrl_t            win_ctrl;
    logic [CHAR_W-1:0]    head;

    // Clamp the length and width registers to what the stores hold; a zero width counts as one
    assign len_eff   = (msg_len_reg > MSG_DEPTH_L) ? MSG_DEPTH_L : msg_len_reg;
    assign width_eff = (win_width_reg == '0) ? LEN_W'(1)
                     : (win_width_reg > WIN_DEPTH_L) ? WIN_DEPTH_L : win_width_reg;
    assign last_idx  = WIN_IDX_W'(width_eff - LEN_W'(1));

    // Feed count k: the pointer while the message runs, else zero on a wrap
    assign fetch_k   = (msg_ptr_reg < len_eff) ? msg_ptr_reg : '0;
    assign fetch_idx = direction_reg ? (len_eff - LEN_W'(1) - fetch_k) : fetch_k;

    assign item_ready = (state_reg == ST_IDLE);
    assign item_beat  = item_valid && item_ready;
    assign ram_we     = item_beat && (command == CMD_WRITE);

    tmq_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MSG_DEPTH)
    ) u_msg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (MSG_IDX_W'(char_index)),
        .wdata (char_value),
        .raddr (MSG_IDX_W'(fetch_idx)),
        .rdata (ram_rdata)
    );

    tmq_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (win_ctrl),
        .last_idx (last_idx),
        .head     (head)
    );

    // Sequencer: next state, counters and window control
    always_comb
    begin
        state_next       = state_reg;
        msg_ptr_next     = msg_ptr_reg;
        gap_cnt_next     = gap_cnt_reg;
        tick_cnt_next    = tick_cnt_reg;
        pos_next         = pos_reg;
        feed_space_next  = feed_space_reg;
        win_ctrl.clear     = 1'b0;
        win_ctrl.advance   = 1'b0;
        win_ctrl.rotate    = 1'b0;
        win_ctrl.dir       = direction_reg;
        win_ctrl.feed_char = feed_space_reg ? SPACE_CODE : ram_rdata;
        result_valid     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_beat)
                begin
                    case (command)
                        CMD_RESTART:
                        begin
                            win_ctrl.clear = 1'b1;
                            msg_ptr_next   = '0;
                            gap_cnt_next   = '0;
                            tick_cnt_next  = '0;
                        end
                        CMD_TICK:
                        begin
                            if (tick_cnt_reg < step_div_reg)
                            begin
                                tick_cnt_next = tick_cnt_reg + DIV_W'(1);
                            end
                            else
                            begin
                                tick_cnt_next = '0;
                                pos_next      = '0;
                                state_next    = ST_SHIFT;
                                if (msg_ptr_reg < len_eff)
                                begin
                                    feed_space_next = 1'b0;
                                    msg_ptr_next    = msg_ptr_reg + LEN_W'(1);
                                end
                                else if (width_eff > len_eff)
                                begin
                                    // Gap space; after the last one restart the message
                                    feed_space_next = 1'b1;
                                    if (gap_cnt_reg == (width_eff - len_eff))
                                    begin
                                        gap_cnt_next = '0;
                                        msg_ptr_next = '0;
                                    end
                                    else
                                    begin
                                        gap_cnt_next = gap_cnt_reg + LEN_W'(1);
                                    end
                                end
                                else
                                begin
                                    // Message fills the window: wrap with no gap
                                    feed_space_next = 1'b0;
                                    msg_ptr_next    = LEN_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // Writes go straight to the RAM; unused codes drop
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                win_ctrl.advance = 1'b1;
                state_next       = ST_EMIT;
            end
            ST_EMIT:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    win_ctrl.rotate = 1'b1;
                    pos_next        = pos_reg + WIN_IDX_W'(1);
                    if (pos_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign position = POS_W'(pos_reg);
    assign glyph    = head;
    assign last     = (pos_reg == last_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            msg_ptr_reg    <= '0;
            gap_cnt_reg    <= '0;
            tick_cnt_reg   <= '0;
            pos_reg        <= '0;
            feed_space_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            msg_ptr_reg    <= msg_ptr_next;
            gap_cnt_reg    <= gap_cnt_next;
            tick_cnt_reg   <= tick_cnt_next;
            pos_reg        <= pos_next;
            feed_space_reg <= feed_space_next;
        end
    end

    // Configuration registers: take the write on the enable, no handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            step_div_reg  <= '0;
            msg_len_reg   <= LEN_W'(1);
            win_width_reg <= WIN_DEPTH_L;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DIRECTION: direction_reg <= cfg_data[0];
                CFG_STEP_DIV:  step_div_reg  <= cfg_data[DIV_W-1:0];
                CFG_MSG_LEN:   msg_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_WIN_WIDTH: win_width_reg <= cfg_data[LEN_W-1:0];
                default:       direction_reg <= direction_reg;
            endcase
        end
    end

endmodule

// ===== tb/tb_text_marquee_scroller_top.sv =====
// Self-checking testbench for text_marquee_scroller_top: directed table, then random phases.
// Depends on tmq_pkg and the scroller RTL; holds its own model of window, message and counters.

module tb_text_marquee_scroller_top;

    import tmq_pkg::*;

    // Command 3 has no name in the package; the block must ignore it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES    = 8;              // a write or skipped tick may still be in flight
    localparam int TAIL_CYCLES      = WIN_DEPTH + 4;  // one full run of beats plus overhead
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES     = 1_000_000;
    localparam int PHASES           = 10;
    localparam int ITEMS_PER_PHASE  = 22;
    localparam int PLAN_ROWS        = 34;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] glyph;
        logic              last;
    } beat_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    // sel carries the command for an item row and the register index for a register row
    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        sel;
        logic [IDX_W-1:0]  idx;
        logic [CHAR_W-1:0] val;
        logic              typed;
        logic [CHAR_W-1:0] glyph;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    logic [CMD_W-1:0]     command;
    logic [IDX_W-1:0]     char_index;
    logic [CHAR_W-1:0]    char_value;
    logic                 result_valid;
    logic                 result_ready;
    logic [POS_W-1:0]     position;
    logic [CHAR_W-1:0]    glyph;
    logic                 last;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Model state: window, message store, counters and registers
    logic [CHAR_W-1:0] win_mem [WIN_DEPTH];
    logic [CHAR_W-1:0] msg_mem [MSG_DEPTH];
    int                feed_count;
    int                gap_count;
    int                skip_count;
    logic              dir_q;
    logic [7:0]        div_q;
    logic [6:0]        len_q;
    logic [6:0]        width_q;

    // Window beats still owed by the block, oldest first
    beat_t beats_q [$];

    int   mismatch_count = 0;
    int   items_sent     = 0;
    int   runs_seen      = 0;
    int   beats_checked  = 0;
    int   reg_writes     = 0;
    int   cyc            = 0;
    bit   quiet          = 1'b0;
    bit   hold_req       = 1'b0;

    // Directed table. A typed glyph is the character expected at the open end
    // of the window on that tick; it replaces the model's value for that beat.
    row_t plan [PLAN_ROWS] = '{
        '{ROW_ITEM, CMD_WRITE,     6'd0,  8'h41, 1'b0, 8'h00},  // message head 'A'
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b1, 8'h41},  // first advance after reset
        '{ROW_ITEM, CMD_WRITE,     6'd63, 8'hFF, 1'b0, 8'h00},  // top index, top code
        '{ROW_ITEM, CMD_WRITE,     6'd1,  8'h00, 1'b0, 8'h00},  // code zero
        '{ROW_ITEM, CMD_UNUSED,    6'd63, 8'hFF, 1'b0, 8'h00},  // ignored command
        '{ROW_ITEM, CMD_TICK,      6'd63, 8'hFF, 1'b1, 8'h20},  // message done, gap space
        '{ROW_REG,  CFG_MSG_LEN,   6'd0,  8'd64, 1'b0, 8'h00},
        '{ROW_REG,  CFG_DIRECTION, 6'd0,  8'h01, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_RESTART,   6'd0,  8'h00, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b1, 8'hFF},  // backward feed starts at the end
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b0, 8'h00},
        '{ROW_REG,  CFG_WIN_WIDTH, 6'd0,  8'd1,  1'b0, 8'h00},  // single position window
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b0, 8'h00},
        '{ROW_REG,  CFG_DIRECTION, 6'd0,  8'hFE, 1'b0, 8'h00},  // flip mid-message, keep the count
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b0, 8'h00},
        '{ROW_REG,  CFG_MSG_LEN,   6'd0,  8'd2,  1'b0, 8'h00},  // pointer already past length
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b1, 8'h41},  // wraps with no gap
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b1, 8'h00},
        '{ROW_REG,  CFG_MSG_LEN,   6'd0,  8'd0,  1'b0, 8'h00},  // empty message
        '{ROW_REG,  CFG_WIN_WIDTH, 6'd0,  8'd0,  1'b0, 8'h00},  // zero width acts as one
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b1, 8'h20},
        '{ROW_REG,  CFG_WIN_WIDTH, 6'd0,  8'hFF, 1'b0, 8'h00},  // saturates to full depth
        '{ROW_REG,  CFG_MSG_LEN,   6'd0,  8'hC1, 1'b0, 8'h00},  // saturates to full depth
        '{ROW_ITEM, CMD_RESTART,   6'd0,  8'h00, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b1, 8'h41},
        '{ROW_REG,  CFG_STEP_DIV,  6'd0,  8'hFF, 1'b0, 8'h00},  // slowest stepping
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_RESTART,   6'd0,  8'h00, 1'b0, 8'h00},  // clears the skip count
        '{ROW_REG,  CFG_STEP_DIV,  6'd0,  8'd2,  1'b0, 8'h00},
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_TICK,      6'd0,  8'h00, 1'b1, 8'h41},  // third tick advances
        '{ROW_REG,  CFG_STEP_DIV,  6'd0,  8'd0,  1'b0, 8'h00}
    };

    text_marquee_scroller_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .char_index   (char_index),
        .char_value   (char_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .position     (position),
        .glyph        (glyph),
        .last         (last),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cyc <= cyc + 1;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Apply one accepted item to the model and queue the window beats it owes.
    task automatic marquee_step(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                input logic [CHAR_W-1:0] val, output int n_beats);
        int                w;
        int                len;
        logic [CHAR_W-1:0] c;
        n_beats = 0;
        case (cmd)
            CMD_WRITE:
                msg_mem[idx] = val;
            CMD_RESTART:
            begin
                foreach (win_mem[i])
                    win_mem[i] = SPACE_CODE;
                feed_count = 0;
                gap_count  = 0;
                skip_count = 0;
            end
            CMD_TICK:
            begin
                if (skip_count < int'(div_q))
                    skip_count++;
                else
                begin
                    skip_count = 0;
                    w   = (width_q == 0) ? 1 : ((width_q > WIN_DEPTH) ? WIN_DEPTH : int'(width_q));
                    len = (len_q > MSG_DEPTH) ? MSG_DEPTH : int'(len_q);
                    // Pick the character for the open end: message, gap space, or wrap
                    if (feed_count < len)
                    begin
                        c = msg_mem[dir_q ? (len - 1 - feed_count) : feed_count];
                        feed_count++;
                    end
                    else if (w > len)
                    begin
                        c = SPACE_CODE;
                        if (gap_count == w - len)
                        begin
                            gap_count  = 0;
                            feed_count = 0;
                        end
                        else
                            gap_count = (gap_count + 1) & 'h7F;
                    end
                    else
                    begin
                        c = msg_mem[dir_q ? (len - 1) : 0];
                        feed_count = 1;
                    end
                    if (dir_q)
                    begin
                        for (int i = w - 1; i > 0; i--)
                            win_mem[i] = win_mem[i - 1];
                        win_mem[0] = c;
                    end
                    else
                    begin
                        for (int i = 0; i < w - 1; i++)
                            win_mem[i] = win_mem[i + 1];
                        win_mem[w - 1] = c;
                    end
                    for (int i = 0; i < w; i++)
                        beats_q.push_back('{pos: POS_W'(i), glyph: win_mem[i], last: (i == w - 1)});
                    n_beats = w;
                    runs_seen++;
                end
            end
            default: ;
        endcase
    endtask

    // Offer one item; called and returning at a falling edge. Valid stays high
    // across back-to-back items, so it is only dropped for a deliberate gap.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [CHAR_W-1:0] val, output int n_beats);
        if (!quiet && cyc[7] && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        char_index <= idx;
        char_value <= val;
        do
            @(posedge clk);
        while (!item_ready);
        marquee_step(cmd, idx, val, n_beats);
        items_sent++;
        @(negedge clk);
    endtask

    // Write a register once the block has drained; called at a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DAT_W-1:0] data);
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (beats_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (sel)
            CFG_DIRECTION: dir_q   = data[0];
            CFG_STEP_DIV:  div_q   = data;
            CFG_MSG_LEN:   len_q   = data[6:0];
            CFG_WIN_WIDTH: width_q = data[6:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Result checker: compare every accepted beat with the oldest one owed
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (beats_q.size() == 0)
                report_mismatch("beat with none owed", int'(glyph), 0);
            else
            begin
                want = beats_q.pop_front();
                if (position !== want.pos)
                    report_mismatch("position", int'(position), int'(want.pos));
                if (glyph !== want.glyph)
                    report_mismatch($sformatf("glyph at %0d", want.pos), int'(glyph),
                                    int'(want.glyph));
                if (last !== want.last)
                    report_mismatch($sformatf("last at %0d", want.pos), int'(last),
                                    int'(want.last));
            end
            beats_checked++;
        end
    end

    // Receiver: random stall bursts while bit 8 of the cycle count is set, plus
    // one long hold-off on request so the block backs up into its input.
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            if (!quiet && cyc[8] && $urandom_range(0, 7) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    // Watchdog: covers the slowest legal run several times over
    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int                n;
        int                counted;
        int                r;
        bit                paused;
        logic [CMD_W-1:0]  cmd;
        logic [7:0]        w_sel;
        logic [7:0]        l_sel;

        // Hold every input at a known value and the block in reset
        rst_n      = 1'b0;
        item_valid = 1'b0;
        command    = CMD_TICK;
        char_index = '0;
        char_value = '0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_DIRECTION;
        cfg_data   = '0;

        foreach (win_mem[i])
            win_mem[i] = SPACE_CODE;
        feed_count = 0;
        gap_count  = 0;
        skip_count = 0;
        dir_q      = 1'b0;
        div_q      = 8'd0;
        len_q      = 7'd1;
        width_q    = 7'd64;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Preload the whole message store so no unwritten entry is ever fed
        for (int i = 0; i < MSG_DEPTH; i++)
            send_item(CMD_WRITE, IDX_W'(i), CHAR_W'($urandom_range(0, 255)), n);

        // Directed part: walk the table
        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_REG)
                write_reg(plan[k].sel, plan[k].val);
            else
            begin
                send_item(plan[k].sel, plan[k].idx, plan[k].val, n);
                // Typed glyph replaces the open-end beat: last for left, first for right
                if (plan[k].typed && n > 0)
                    beats_q[beats_q.size() - (dir_q ? n : 1)].glyph = plan[k].glyph;
            end
        end

        // Random phases: fresh settings each phase, mostly small windows and fast stepping
        for (int phase = 0; phase < PHASES; phase++)
        begin
            quiet = (phase == PHASES - 1);
            case ($urandom_range(0, 9))
                0:       w_sel = 8'd64;
                1:       w_sel = 8'd0;
                2:       w_sel = 8'($urandom_range(65, 255));
                default: w_sel = 8'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       l_sel = 8'd64;
                1:       l_sel = 8'd0;
                2:       l_sel = 8'($urandom_range(65, 255));
                3:       l_sel = w_sel;
                default: l_sel = 8'($urandom_range(1, 10));
            endcase
            write_reg(CFG_WIN_WIDTH, w_sel);
            write_reg(CFG_MSG_LEN, l_sel);
            write_reg(CFG_DIRECTION, 8'($urandom_range(0, 255)));
            write_reg(CFG_STEP_DIV, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3)) : 8'd0);
            if ($urandom_range(0, 1) == 1)
                send_item(CMD_RESTART, IDX_W'($urandom), CHAR_W'($urandom), n);

            // Starve the result side for a long stretch while items keep coming
            if (phase == 2)
                hold_req = 1'b1;

            counted = 0;
            paused  = 1'b0;
            while (counted < ITEMS_PER_PHASE)
            begin
                // Drop valid and wait for the block to empty completely once
                if (phase == 5 && !paused && counted == ITEMS_PER_PHASE / 2)
                begin
                    paused = 1'b1;
                    item_valid <= 1'b0;
                    do
                        @(negedge clk);
                    while (beats_q.size() != 0);
                end
                r = $urandom_range(0, 99);
                if (r < 70)
                    cmd = CMD_TICK;
                else if (r < 88)
                    cmd = CMD_WRITE;
                else if (r < 94)
                    cmd = CMD_RESTART;
                else
                    cmd = CMD_UNUSED;
                send_item(cmd, IDX_W'($urandom), CHAR_W'($urandom), n);
                if (cmd != CMD_UNUSED)
                    counted++;
            end
        end

        // Drain: wait for every owed beat, then a run's worth of extra cycles
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (beats_q.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (beats_q.size() != 0)
            report_mismatch("beats left over", beats_q.size(), 0);

        $display("Run covered %0d items, %0d window advances and %0d beats checked,",
                 items_sent, runs_seen, beats_checked);
        $display("over %0d register writes spanning both directions and all width extremes.",
                 reg_writes);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
